@@ src/lpgc_pkg.sv @@
// Package for the linear probing group-count block: table geometry,
// status codes and storage word layout. No dependencies.
package lpgc_pkg;

   // Table geometry. Both sizes are powers of two.
   localparam int TABLE_SIZE = 1024;
   localparam int LANES      = 16;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam int LANE_W     = $clog2(LANES);
   localparam int ROWS       = TABLE_SIZE / LANES;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int WIN_MAX    = 2 * ((TABLE_SIZE + LANES - 1) / LANES);
   localparam int WIN_W      = $clog2(WIN_MAX);

   // Field widths.
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = KEY_W + COUNT_W;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INCREMENTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_KEY_ZERO    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READOUT     = 3'd4;

   // Command codes.
   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Controller states.
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_EVAL  = 2'd3;

   typedef logic [ENTRY_W-1:0] entry_type;

endpackage

@@ src/linear_probe_group_count.sv @@
// Linear probing hash table that counts occurrences of keys, with slot readout.
// Bank memories, probe control and result register. Depends on lpgc_pkg.
//
// The table is held in LANES memory banks, slot s in bank s mod LANES, so a
// window of LANES consecutive slots is read together. After reset a clearing
// pass writes all ROWS (64) rows of every bank, while no word is accepted;
// configuration writes are taken throughout. A read word goes through accept,
// bank read and evaluate, a word with key zero through accept and evaluate,
// and a count word through accept and then a bank read and an evaluate step
// for each window probed; the single write-back to the chosen bank happens
// in an evaluate step. One word is worked on at a time; the finished word
// waits in the result register while the next word is accepted.
module linear_probe_group_count
   import lpgc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration: hash multiplier.
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // key[31:0], slot_index[41:32], zero fill
   input  logic        req_tuser,   // cmd
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // slot[9:0], slot_key[41:10],
                                    // slot_count[73:42], zero fill
   output logic [2:0]  rsp_tuser    // status
);

   // Bank storage: key in the low half of an entry, count in the high half.
   entry_type bank_mem [LANES][ROWS];
   entry_type rd_ff [LANES];

   logic [1:0]        state_ff, state_in;
   logic [ROW_W-1:0]  clr_row_ff, clr_row_in;
   logic [31:0]       mult_ff;
   logic [SLOT_W-1:0] start_ff, start_in;
   logic [SLOT_W-1:0] first_ff, first_in;
   logic [WIN_W-1:0]  win_cnt_ff, win_cnt_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              read_ff, read_in;
   logic              zero_ff, zero_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [LANES-1:0]  wr_en;
   logic [ROW_W-1:0]  wr_row;
   entry_type         wr_data;
   logic [ROW_W-1:0]  rd_row [LANES];

   logic [KEY_W-1:0]   lane_key   [LANES];
   logic [COUNT_W-1:0] lane_count [LANES];
   logic [LANES-1:0]   lane_valid;

   logic              hit, empty;
   logic [LANE_W-1:0] hit_lane, empty_lane;
   logic [SLOT_W:0]   sel_slot;
   logic [SLOT_W:0]   next_start;
   logic [COUNT_W-1:0] hit_count;
   logic              out_free;
   logic              accept;
   logic [SLOT_W-1:0] hash_prod;
   logic              rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // Only the low slot bits of key times multiplier select the start slot.
   assign hash_prod  = SLOT_W'(req_tdata[SLOT_W-1:0] * mult_ff[SLOT_W-1:0]);

   // Per-bank read row: bank b holds window lane (b - start) mod LANES.
   always_comb begin
      logic [LANE_W-1:0] ofs;
      logic [SLOT_W:0]   s;
      for (int b = 0; b < LANES; b++) begin
         ofs       = LANE_W'(b) - start_ff[LANE_W-1:0];
         s         = {1'b0, start_ff} + {{(SLOT_W+1-LANE_W){1'b0}}, ofs};
         rd_row[b] = s[SLOT_W-1:LANE_W];
      end
   end

   // Bank memories: one write and one registered read per bank each cycle.
   always_ff @(posedge clock) begin
      for (int b = 0; b < LANES; b++) begin
         if (wr_en[b]) begin
            bank_mem[b][wr_row] <= wr_data;
         end
         rd_ff[b] <= bank_mem[b][rd_row[b]];
      end
   end

   // Rotate the bank outputs into window order and mark lanes past the end.
   always_comb begin
      logic [LANE_W-1:0] bk;
      logic [SLOT_W:0]   s;
      for (int i = 0; i < LANES; i++) begin
         bk            = start_ff[LANE_W-1:0] + LANE_W'(i);
         s             = {1'b0, start_ff} + (SLOT_W+1)'(i);
         lane_key[i]   = rd_ff[bk][KEY_W-1:0];
         lane_count[i] = rd_ff[bk][ENTRY_W-1:KEY_W];
         lane_valid[i] = !s[SLOT_W];
      end
   end

   // Lowest matching lane and lowest empty lane of the window.
   always_comb begin
      hit        = 1'b0;
      empty      = 1'b0;
      hit_lane   = '0;
      empty_lane = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (lane_valid[i] && lane_key[i] == key_ff) begin
            hit      = 1'b1;
            hit_lane = LANE_W'(i);
         end
         if (lane_valid[i] && lane_key[i] == '0) begin
            empty      = 1'b1;
            empty_lane = LANE_W'(i);
         end
      end
   end

   assign hit_count = (lane_count[hit_lane] == '1) ? lane_count[hit_lane]
                                                   : lane_count[hit_lane] + 1'b1;
   assign sel_slot   = {1'b0, start_ff}
                     + {{(SLOT_W+1-LANE_W){1'b0}}, hit ? hit_lane : empty_lane};
   assign next_start = {1'b0, start_ff} + (SLOT_W+1)'(LANES);

   // Control, write-back and result selection.
   always_comb begin
      state_in      = state_ff;
      clr_row_in    = clr_row_ff;
      start_in      = start_ff;
      first_in      = first_ff;
      win_cnt_in    = win_cnt_ff;
      key_in        = key_ff;
      read_in       = read_ff;
      zero_in       = zero_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_load      = 1'b0;
      wr_en         = '0;
      wr_row        = sel_slot[SLOT_W-1:LANE_W];
      wr_data       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en      = '1;
            wr_row     = clr_row_ff;
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               key_in     = req_tdata[KEY_W-1:0];
               read_in    = (req_tuser == CMD_READ);
               zero_in    = (req_tdata[KEY_W-1:0] == '0);
               win_cnt_in = '0;
               if (req_tuser == CMD_READ) begin
                  start_in = req_tdata[KEY_W+SLOT_W-1:KEY_W];
                  state_in = S_READ;
               end else begin
                  start_in = hash_prod;
                  state_in = (req_tdata[KEY_W-1:0] == '0) ? S_EVAL : S_READ;
               end
               first_in = start_in;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (read_ff) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_READOUT;
                  rsp_slot_in   = start_ff;
                  rsp_key_in    = lane_key[0];
                  rsp_count_in  = lane_count[0];
               end
            end else if (zero_ff) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_KEY_ZERO;
                  rsp_slot_in   = '0;
                  rsp_key_in    = '0;
                  rsp_count_in  = '0;
               end
            end else if (hit || empty) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = hit ? ST_INCREMENTED : ST_INSERTED;
                  rsp_slot_in   = sel_slot[SLOT_W-1:0];
                  rsp_key_in    = key_ff;
                  rsp_count_in  = hit ? hit_count : COUNT_W'(1);
                  wr_en[sel_slot[LANE_W-1:0]] = 1'b1;
                  wr_data       = {rsp_count_in, key_ff};
               end
            end else if (win_cnt_ff == WIN_W'(WIN_MAX - 1)) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_FULL;
                  rsp_slot_in   = first_ff;
                  rsp_key_in    = '0;
                  rsp_count_in  = '0;
               end
            end else begin
               // Move on to the next window, wrapping at the table end.
               start_in   = next_start[SLOT_W] ? '0 : next_start[SLOT_W-1:0];
               win_cnt_in = win_cnt_ff + 1'b1;
               state_in   = S_READ;
            end
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_row_ff   <= '0;
         mult_ff      <= 32'd1;
         rsp_valid_ff <= 1'b0;
         win_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
         win_cnt_ff   <= win_cnt_in;
         if (csr_wr_en) begin
            mult_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      first_ff      <= first_in;
      key_ff        <= key_in;
      read_ff       <= read_in;
      zero_ff       <= zero_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_key_ff, rsp_slot_ff};

   // No word is taken while the clearing pass runs.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready)
      else $error("word accepted during clearing pass");

   // Outside the clearing pass the banks are written only when a result is loaded.
   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      (wr_en != '0) && state_ff != S_CLEAR |-> rsp_load && $onehot(wr_en))
      else $error("bank write without a result");

   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten");

endmodule
